>>> rtl/text_grid_terminal_writer_core_macros.svh
// Assertion macros used by the checker file of the text grid writer.
`ifndef TEXT_GRID_TERMINAL_WRITER_CORE_MACROS_SVH
`define TEXT_GRID_TERMINAL_WRITER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TGTW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TGTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tgtw_pkg.sv
package tgtw_pkg;

  // Request payload.
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tgtw_in_t;

  // Result payload.
  typedef struct packed {
    logic [6:0] cell_char;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       did_scroll;
  } tgtw_out_t;

  // Request types.
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Character codes.
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_TAB = 8'd9;
  localparam logic [7:0] CODE_NL  = 8'd10;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;
  localparam logic [6:0] BLANK    = 7'h20;

  localparam int TAB_SPACES = 4;
  localparam int TAB_W      = $clog2(TAB_SPACES);

  // Microprogram step labels.
  typedef enum logic [3:0] {
    U_IDLE, U_INIT, U_PUT, U_NL, U_SCRL, U_TABCHK, U_CR,
    U_BS, U_BSW, U_CLR, U_READ, U_RDW, U_DONE
  } step_t;

  // Datapath actions.
  typedef enum logic [3:0] {
    A_NONE, A_ACCEPT, A_PUT, A_NEWLINE, A_ROW_CLR, A_GRID_CLR,
    A_TAB_DEC, A_CR, A_BS_STEP, A_RD_TAKE, A_FINISH
  } act_t;

  // Memory address sources.
  typedef enum logic [1:0] {AS_CUR, AS_CLR, AS_READ} asel_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER, C_DISPATCH, C_WRAP, C_NO_SCROLL, C_ROW_MORE,
    C_GRID_MORE, C_TAB_LEFT, C_COL_ZERO, C_OUT_BUSY
  } cond_t;

  // One control word: action, memory control, then the jump.
  typedef struct packed {
    act_t  act;
    asel_t asel;
    logic  we;
    cond_t cond;
    step_t tgt;
    step_t nxt;
  } uword_t;

  // Microprogram ROM: a true condition goes to tgt, otherwise to nxt; C_DISPATCH uses dispatch().
  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    unique case (pc)
      U_IDLE:   w = '{A_ACCEPT,   AS_CUR,  1'b0, C_DISPATCH,  U_IDLE,   U_IDLE};
      U_INIT:   w = '{A_GRID_CLR, AS_CLR,  1'b1, C_GRID_MORE, U_INIT,   U_IDLE};
      U_PUT:    w = '{A_PUT,      AS_CUR,  1'b1, C_WRAP,      U_NL,     U_TABCHK};
      U_NL:     w = '{A_NEWLINE,  AS_CUR,  1'b0, C_NO_SCROLL, U_TABCHK, U_SCRL};
      U_SCRL:   w = '{A_ROW_CLR,  AS_CLR,  1'b1, C_ROW_MORE,  U_SCRL,   U_TABCHK};
      U_TABCHK: w = '{A_TAB_DEC,  AS_CUR,  1'b0, C_TAB_LEFT,  U_PUT,    U_DONE};
      U_CR:     w = '{A_CR,       AS_CUR,  1'b0, C_NEVER,     U_DONE,   U_DONE};
      U_BS:     w = '{A_BS_STEP,  AS_CUR,  1'b0, C_COL_ZERO,  U_DONE,   U_BSW};
      U_BSW:    w = '{A_NONE,     AS_CUR,  1'b1, C_NEVER,     U_DONE,   U_DONE};
      U_CLR:    w = '{A_GRID_CLR, AS_CLR,  1'b1, C_GRID_MORE, U_CLR,    U_DONE};
      U_READ:   w = '{A_NONE,     AS_READ, 1'b0, C_NEVER,     U_RDW,    U_RDW};
      U_RDW:    w = '{A_RD_TAKE,  AS_READ, 1'b0, C_NEVER,     U_DONE,   U_DONE};
      U_DONE:   w = '{A_FINISH,   AS_CUR,  1'b0, C_OUT_BUSY,  U_DONE,   U_IDLE};
      default:  w = '{A_NONE,     AS_CUR,  1'b0, C_NEVER,     U_IDLE,   U_IDLE};
    endcase
    return w;
  endfunction

  // Entry point of the microprogram for a newly accepted request.
  function automatic step_t dispatch(input tgtw_in_t req);
    step_t s;
    priority if (req.req_type == REQ_READ) begin
      s = U_READ;
    end else if (req.req_type == REQ_CLEAR) begin
      s = U_CLR;
    end else if (req.req_type != REQ_PUT) begin
      s = U_DONE;
    end else if (req.char_code == CODE_NL) begin
      s = U_NL;
    end else if (req.char_code == CODE_CR) begin
      s = U_CR;
    end else if (req.char_code == CODE_BS) begin
      s = U_BS;
    end else if (req.char_code == CODE_TAB) begin
      s = U_PUT;
    end else if (req.char_code >= PRINT_LO && req.char_code <= PRINT_HI) begin
      s = U_PUT;
    end else begin
      s = U_DONE;
    end
    return s;
  endfunction

endpackage

>>> rtl/tgtw_ram.sv
module tgtw_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 2816
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/text_grid_terminal_writer_core.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_data  (tgtw_in_t: type, byte, read row/col)
// out     | output    | out_valid/out_stall| out_data (tgtw_out_t: cell, cursor, scroll flag)
//
// A microprogram takes one request at a time; one grid memory port sets the pace.
// Steps: printable byte PUT, TABCHK, DONE; newline NL, TABCHK, DONE; read READ, RDW, DONE;
// return CR, DONE; backspace BS, BSW (skipped at column 0), DONE; tab PUT, TABCHK per space;
// ignored byte or unused type DONE. A wrap adds NL, each scroll a SCRL pass over one row, a clear
// request a CLR pass over the grid. After reset a clearing pass runs before the first accept.
// The result register waits out an output stall; the next request is taken meanwhile.
module text_grid_terminal_writer_core #(
  parameter int GRID_COLS = 78,
  parameter int GRID_ROWS = 22
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tgtw_pkg::tgtw_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tgtw_pkg::tgtw_out_t out_data
);

  import tgtw_pkg::*;

  localparam int CW        = $clog2(GRID_COLS);
  localparam int RW        = $clog2(GRID_ROWS);
  localparam int RAM_DEPTH = GRID_ROWS * (2 ** CW);
  localparam int AW        = $clog2(RAM_DEPTH);

  localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
  localparam logic [RW:0]   ROW_LIM  = (RW + 1)'(GRID_ROWS);
  localparam logic [7:0]    COL_LIM8 = 8'(GRID_COLS);
  localparam logic [5:0]    ROW_LIM6 = 6'(GRID_ROWS);

  // Sequencer and datapath registers.
  step_t           step_r, step_nxt;
  logic [CW-1:0]   cur_col_r, cur_col_nxt;
  logic [RW-1:0]   cur_row_r, cur_row_nxt;
  logic [RW-1:0]   top_r, top_nxt;
  logic [CW-1:0]   clr_col_r, clr_col_nxt;
  logic [RW-1:0]   clr_row_r, clr_row_nxt;
  logic [TAB_W-1:0] tab_left_r, tab_left_nxt;
  logic            scrolled_r, scrolled_nxt;
  logic [6:0]      char_r, char_nxt;
  logic [RW-1:0]   rd_row_r, rd_row_nxt;
  logic [CW-1:0]   rd_col_r, rd_col_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic [6:0]      cell_r, cell_nxt;
  logic            out_valid_r, out_valid_nxt;
  tgtw_out_t       out_data_r, out_data_nxt;

  uword_t          uw;
  logic            cond_true;
  logic            out_busy;
  logic            rd_in_range;
  logic [RW-1:0]   log_row;
  logic [RW:0]     row_sum;
  logic [RW-1:0]   phys_row;
  logic [AW-1:0]   ram_addr;
  logic [6:0]      ram_wdata;
  logic [6:0]      ram_rdata;

  // Current control word.
  assign uw       = ucode(step_r);
  assign in_stall = (uw.cond != C_DISPATCH);
  assign out_busy = out_valid_r && out_stall;

  assign rd_in_range = ({1'b0, in_data.read_row} < ROW_LIM6) &&
                       ({1'b0, in_data.read_col} < COL_LIM8);

  // Jump condition select.
  always_comb begin
    unique case (uw.cond)
      C_WRAP:      cond_true = (cur_col_r == COL_LAST);
      C_NO_SCROLL: cond_true = (cur_row_r != ROW_LAST);
      C_ROW_MORE:  cond_true = (clr_col_r != COL_LAST);
      C_GRID_MORE: cond_true = !((clr_col_r == COL_LAST) && (clr_row_r == ROW_LAST));
      C_TAB_LEFT:  cond_true = (tab_left_r != '0);
      C_COL_ZERO:  cond_true = (cur_col_r == '0);
      C_OUT_BUSY:  cond_true = out_busy;
      default:     cond_true = 1'b0;
    endcase
  end

  // Step counter: dispatch on accept, otherwise a two-way jump.
  always_comb begin
    if (uw.cond == C_DISPATCH) begin
      step_nxt = in_valid ? dispatch(in_data) : uw.nxt;
    end else begin
      step_nxt = cond_true ? uw.tgt : uw.nxt;
    end
  end

  // Rows live in a ring; top_r is the memory row shown as row 0.
  assign log_row  = (uw.asel == AS_READ) ? rd_row_r : cur_row_r;
  assign row_sum  = {1'b0, log_row} + {1'b0, top_r};
  assign phys_row = (row_sum >= ROW_LIM) ? RW'(row_sum - ROW_LIM) : row_sum[RW-1:0];

  // Memory address and write data.
  always_comb begin
    unique case (uw.asel)
      AS_CUR:  ram_addr = {phys_row, cur_col_r};
      AS_CLR:  ram_addr = {clr_row_r, clr_col_r};
      AS_READ: ram_addr = {phys_row, rd_col_r};
      default: ram_addr = {clr_row_r, clr_col_r};
    endcase
  end

  assign ram_wdata = (uw.act == A_PUT) ? char_r : BLANK;

  tgtw_ram #(
    .WIDTH (7),
    .DEPTH (RAM_DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (uw.we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Datapath actions.
  always_comb begin
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    top_nxt      = top_r;
    clr_col_nxt  = clr_col_r;
    clr_row_nxt  = clr_row_r;
    tab_left_nxt = tab_left_r;
    scrolled_nxt = scrolled_r;
    char_nxt     = char_r;
    rd_row_nxt   = rd_row_r;
    rd_col_nxt   = rd_col_r;
    rd_ok_nxt    = rd_ok_r;
    cell_nxt     = cell_r;
    unique case (uw.act)
      A_ACCEPT: begin
        if (in_valid) begin
          char_nxt     = (in_data.char_code == CODE_TAB) ? BLANK : in_data.char_code[6:0];
          tab_left_nxt = (in_data.req_type == REQ_PUT && in_data.char_code == CODE_TAB) ?
                         TAB_W'(TAB_SPACES - 1) : '0;
          rd_ok_nxt    = rd_in_range;
          rd_row_nxt   = rd_in_range ? in_data.read_row[RW-1:0] : '0;
          rd_col_nxt   = rd_in_range ? in_data.read_col[CW-1:0] : '0;
          scrolled_nxt = 1'b0;
          cell_nxt     = BLANK;
          if (in_data.req_type == REQ_CLEAR) begin
            cur_col_nxt = '0;
            cur_row_nxt = '0;
            top_nxt     = '0;
            clr_col_nxt = '0;
            clr_row_nxt = '0;
          end
        end
      end
      A_PUT: begin
        // At the last column the newline step takes over.
        if (cur_col_r != COL_LAST) begin
          cur_col_nxt = cur_col_r + CW'(1);
        end
      end
      A_NEWLINE: begin
        cur_col_nxt = '0;
        if (cur_row_r == ROW_LAST) begin
          // Scroll: rotate the ring and blank the old top row.
          top_nxt      = (top_r == ROW_LAST) ? '0 : top_r + RW'(1);
          clr_row_nxt  = top_r;
          clr_col_nxt  = '0;
          scrolled_nxt = 1'b1;
        end else begin
          cur_row_nxt = cur_row_r + RW'(1);
        end
      end
      A_ROW_CLR: begin
        clr_col_nxt = clr_col_r + CW'(1);
      end
      A_GRID_CLR: begin
        if (clr_col_r == COL_LAST) begin
          clr_col_nxt = '0;
          clr_row_nxt = clr_row_r + RW'(1);
        end else begin
          clr_col_nxt = clr_col_r + CW'(1);
        end
      end
      A_TAB_DEC: begin
        if (tab_left_r != '0) begin
          tab_left_nxt = tab_left_r - TAB_W'(1);
        end
      end
      A_CR: begin
        cur_col_nxt = '0;
      end
      A_BS_STEP: begin
        if (cur_col_r != '0) begin
          cur_col_nxt = cur_col_r - CW'(1);
        end
      end
      A_RD_TAKE: begin
        cell_nxt = rd_ok_r ? ram_rdata : BLANK;
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (uw.act == A_FINISH && !out_busy) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.cell_char  = cell_r;
      out_data_nxt.cursor_col = 7'(cur_col_r);
      out_data_nxt.cursor_row = 5'(cur_row_r);
      out_data_nxt.did_scroll = scrolled_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= U_INIT;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      top_r       <= '0;
      clr_col_r   <= '0;
      clr_row_r   <= '0;
      tab_left_r  <= '0;
      scrolled_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      top_r       <= top_nxt;
      clr_col_r   <= clr_col_nxt;
      clr_row_r   <= clr_row_nxt;
      tab_left_r  <= tab_left_nxt;
      scrolled_r  <= scrolled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    rd_row_r   <= rd_row_nxt;
    rd_col_r   <= rd_col_nxt;
    rd_ok_r    <= rd_ok_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/tgtw_checker.sv
`include "text_grid_terminal_writer_core_macros.svh"

module tgtw_checker #(
  parameter int GRID_COLS = 78,
  parameter int GRID_ROWS = 22
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tgtw_pkg::tgtw_out_t out_data
);

  import tgtw_pkg::*;

  // A stalled result keeps its value.
  `TGTW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed under stall")

  // Requests are handled one at a time.
  `TGTW_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request accepted while busy")

  // Only printable characters or blanks ever come out of the grid.
  `TGTW_ASSERT_NOW(a_cell_printable, out_valid, out_data.cell_char >= PRINT_LO[6:0] && out_data.cell_char <= PRINT_HI[6:0], "cell character out of range")

  // The cursor stays on the grid.
  `TGTW_ASSERT_NOW(a_cursor_range, out_valid, out_data.cursor_col < GRID_COLS && out_data.cursor_row < GRID_ROWS, "cursor off the grid")

  // A scroll leaves the cursor on the bottom row.
  `TGTW_ASSERT_NOW(a_scroll_row, out_valid && out_data.did_scroll, out_data.cursor_row == GRID_ROWS - 1, "scroll without cursor on last row")

endmodule

bind text_grid_terminal_writer_core tgtw_checker #(
  .GRID_COLS (GRID_COLS),
  .GRID_ROWS (GRID_ROWS)
) u_tgtw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
